// ===== rtl/core/tlpte_pkg.sv =====
`default_nettype none
package tlpte_pkg;

	// operation codes
	typedef enum logic [2:0] {
		OP_MAP       = 3'd0,
		OP_UNMAP     = 3'd1,
		OP_TRANSLATE = 3'd2,
		OP_SET_FLAGS = 3'd3,
		OP_GET_FLAGS = 3'd4,
		OP_DIRTY     = 3'd5
	} op_t;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_MAPPED   = 2'd1;
	localparam logic [1:0] ST_ZERO     = 2'd2;
	localparam logic [1:0] ST_NO_TABLE = 2'd3;

	// entry flag bits
	localparam int BIT_PRESENT  = 0;
	localparam int BIT_WRITABLE = 1;
	localparam int BIT_USER     = 2;
	localparam int BIT_DIRTY    = 6;

	localparam int FLAG_W     = 12;
	localparam int VP_W       = 14;
	localparam int FRAME_W    = 20;
	localparam int COUNT_W    = 15;
	localparam int KTC_W      = 5;
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 72;

	localparam logic [KTC_W-1:0]   KTC_RESET = 5'd8;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 15'h7FFF;

endpackage
`default_nettype wire

// ===== rtl/core/two_level_page_table_engine_top.sv =====
`default_nettype none
// steps: most operations pass idle, eval and fin before the output register; a map that builds a table
// also runs a clearing sweep over the table memory, and an unmap with a table an empty scan and scan end
// flow: one operation at a time; s_axis_tready is high only in idle, so the next operation waits until
// the result of the last one has been loaded into the output register
// reset: arst_n clears the directory valid bits, user page count, fsm and output valid flag;
// the entry memory needs no clearing since every table is zeroed when it is created
module two_level_page_table_engine_top import tlpte_pkg::*; #(
	parameter int DIR_INDEX_BITS   = 4,
	parameter int TABLE_INDEX_BITS = 10,
	parameter int FRAME_BITS       = 20
) (
	input  wire                   clk,
	input  wire                   arst_n,
	// config write channel: kernel_table_count
	input  wire                   cfg_valid,
	output logic                  cfg_ready,
	input  wire  [KTC_W-1:0]      cfg_data,
	// operation input
	input  wire                   s_axis_tvalid,
	output logic                  s_axis_tready,
	// tdata: virt_page[13:0], map_frame[33:14], new_table_frame[53:34], alloc_table[54],
	// kernel_mode[55], not_present[56], require_present[57], flag_bits[69:58], zero pad
	input  wire  [IN_DATA_W-1:0]  s_axis_tdata,
	// tuser: op[2:0]
	input  wire  [2:0]            s_axis_tuser,
	// result output
	output logic                  m_axis_tvalid,
	input  wire                   m_axis_tready,
	// tdata: status[1:0], frame_out[21:2], flags_out[33:22], dirty[34], table_created[35],
	// table_released[36], released_table_frame[56:37], user_pages[71:57]
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	localparam int VA_W  = DIR_INDEX_BITS + TABLE_INDEX_BITS;
	localparam int ENT_W = FRAME_BITS + FLAG_W;
	localparam int SLOTS = 1 << DIR_INDEX_BITS;

	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_EVAL     = 6'b000010,
		S_CLEAR    = 6'b000100,
		S_SCAN     = 6'b001000,
		S_SCAN_END = 6'b010000,
		S_FIN      = 6'b100000
	} state_t;

	state_t state_q;

	// config register
	logic [KTC_W-1:0] ktc_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ktc_q <= KTC_RESET;
		end else if (cfg_valid) begin
			ktc_q <= cfg_data;
		end
	end

	// input field decode
	logic [VP_W-1:0]         in_vp;
	logic [VA_W+VP_W-1:0]    in_vp_wide;
	logic [VA_W-1:0]         in_va;
	logic                    in_xfer;

	assign in_vp      = s_axis_tdata[13:0];
	assign in_vp_wide = {{VA_W{1'b0}}, in_vp};
	assign in_va      = in_vp_wide[VA_W-1:0];
	assign in_xfer    = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);

	// latched operation
	op_t                         op_q;
	logic [VA_W-1:0]             va_q;
	logic [FRAME_BITS-1:0]       pp_q;
	logic [FRAME_BITS-1:0]       ntf_q;
	logic                        alloc_q, kmode_q, notp_q, reqp_q;
	logic [FLAG_W-1:0]           fl_q;
	logic [DIR_INDEX_BITS-1:0]   slot_q;
	logic [TABLE_INDEX_BITS-1:0] tidx_q;

	assign slot_q = va_q[VA_W-1:TABLE_INDEX_BITS];
	assign tidx_q = va_q[TABLE_INDEX_BITS-1:0];

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q    <= op_t'(s_axis_tuser);
			va_q    <= in_va;
			pp_q    <= s_axis_tdata[14 +: FRAME_BITS];
			ntf_q   <= s_axis_tdata[34 +: FRAME_BITS];
			alloc_q <= s_axis_tdata[54];
			kmode_q <= s_axis_tdata[55];
			notp_q  <= s_axis_tdata[56];
			reqp_q  <= s_axis_tdata[57];
			fl_q    <= s_axis_tdata[69:58];
		end
	end

	// directory: valid bit per slot in flops, frame beside it
	logic [SLOTS-1:0]      dir_valid_q;
	logic [FRAME_BITS-1:0] dir_frame_q [SLOTS];
	logic                  have;
	logic                  user_slot;

	assign have      = dir_valid_q[slot_q];
	assign user_slot = {{KTC_W{1'b0}}, slot_q} >= {{DIR_INDEX_BITS{1'b0}}, ktc_q};

	// page entry memory, one write and one registered read per cycle
	logic [ENT_W-1:0] mem [1 << VA_W];
	logic [ENT_W-1:0] mem_rd_q;
	logic             mem_we;
	logic [VA_W-1:0]  mem_waddr, mem_raddr;
	logic [ENT_W-1:0] mem_wdata;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		mem_rd_q <= mem[mem_raddr];
	end

	// sweep counter for table clear and empty scan
	logic [TABLE_INDEX_BITS-1:0] cnt_q;
	logic                        cnt_last;
	logic                        scan_v_s1;
	logic                        nz_q;
	logic                        rd_nz;

	assign cnt_last = &cnt_q;
	assign rd_nz    = scan_v_s1 && (mem_rd_q != '0);

	// entry fields of the read data
	logic                  e_present, e_dirty;
	logic [FRAME_BITS-1:0] e_frame;
	logic [FLAG_W-1:0]     e_flags;
	logic                  already;

	assign e_present = mem_rd_q[BIT_PRESENT];
	assign e_dirty   = mem_rd_q[BIT_DIRTY];
	assign e_frame   = mem_rd_q[ENT_W-1:FLAG_W];
	assign e_flags   = mem_rd_q[FLAG_W-1:0];
	assign already   = have && e_present && (e_frame != '0);

	// entry written by map
	logic [FLAG_W-1:0] map_flags;
	logic [ENT_W-1:0]  map_entry;
	logic              map_counts;

	always_comb begin
		map_flags = '0;
		if (!notp_q) begin
			map_flags[BIT_PRESENT]  = 1'b1;
			map_flags[BIT_WRITABLE] = 1'b1;
		end
		if (!kmode_q) begin
			map_flags[BIT_USER] = 1'b1;
		end
	end
	assign map_entry  = {pp_q, map_flags};
	assign map_counts = !kmode_q && !notp_q;

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = va_q;
		mem_wdata = '0;
		mem_raddr = va_q;
		if (state_q == S_IDLE) begin
			mem_raddr = in_va;
		end else if (state_q == S_SCAN) begin
			mem_raddr = {slot_q, cnt_q};
		end
		if (state_q == S_CLEAR) begin
			// zero the new table, dropping the mapped entry in on the way
			mem_we    = 1'b1;
			mem_waddr = {slot_q, cnt_q};
			mem_wdata = (cnt_q == tidx_q) ? map_entry : '0;
		end else if (state_q == S_EVAL && have) begin
			case (op_q)
				OP_MAP: begin
					mem_we    = !already && (va_q != '0) && (pp_q != '0);
					mem_wdata = map_entry;
				end
				OP_UNMAP: begin
					mem_we    = 1'b1;
					mem_wdata = '0;
				end
				OP_SET_FLAGS: begin
					mem_we    = 1'b1;
					mem_wdata = mem_rd_q | {{FRAME_BITS{1'b0}}, fl_q};
				end
				default: begin
					mem_we = 1'b0;
				end
			endcase
		end
	end

	// result registers
	logic [1:0]            res_status_q;
	logic [FRAME_BITS-1:0] res_frame_q;
	logic [FLAG_W-1:0]     res_flags_q;
	logic                  res_dirty_q, res_created_q, res_released_q;
	logic [FRAME_BITS-1:0] res_rel_frame_q;
	logic                  uncount_q;
	logic [COUNT_W-1:0]    user_cnt_q;
	logic                  out_free;

	assign out_free = !m_axis_tvalid || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dir_valid_q <= '0;
			user_cnt_q  <= '0;
			cnt_q       <= '0;
			scan_v_s1   <= 1'b0;
			nz_q        <= 1'b0;
		end else begin
			scan_v_s1 <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					cnt_q   <= '0;
					nz_q    <= 1'b0;
					state_q <= S_FIN;
					if (op_q == OP_MAP && !already && va_q != '0 && pp_q != '0) begin
						if (!have && alloc_q) begin
							dir_valid_q[slot_q] <= 1'b1;
							state_q             <= S_CLEAR;
						end else if (have && map_counts && user_cnt_q < COUNT_MAX) begin
							user_cnt_q <= user_cnt_q + 1'b1;
						end
					end else if (op_q == OP_UNMAP && have) begin
						state_q <= S_SCAN;
					end
				end
				S_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_last) begin
						if (map_counts && user_cnt_q < COUNT_MAX) begin
							user_cnt_q <= user_cnt_q + 1'b1;
						end
						state_q <= S_FIN;
					end
				end
				S_SCAN: begin
					scan_v_s1 <= 1'b1;
					cnt_q     <= cnt_q + 1'b1;
					if (rd_nz) begin
						nz_q <= 1'b1;
					end
					if (cnt_last) begin
						state_q <= S_SCAN_END;
					end
				end
				S_SCAN_END: begin
					if (!(nz_q || rd_nz)) begin
						dir_valid_q[slot_q] <= 1'b0;
					end
					if (uncount_q && user_cnt_q != '0) begin
						user_cnt_q <= user_cnt_q - 1'b1;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload side of the sequencer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			res_status_q    <= ST_OK;
			res_frame_q     <= '0;
			res_flags_q     <= '0;
			res_dirty_q     <= 1'b0;
			res_created_q   <= 1'b0;
			res_released_q  <= 1'b0;
			res_rel_frame_q <= '0;
		end
		if (state_q == S_EVAL) begin
			uncount_q <= user_slot && e_present;
			if (!have && op_q != OP_MAP && op_q <= OP_DIRTY) begin
				res_status_q <= ST_NO_TABLE;
			end
			case (op_q)
				OP_MAP: begin
					if (already) begin
						res_status_q <= ST_MAPPED;
					end else if (va_q == '0 || pp_q == '0) begin
						res_status_q <= ST_ZERO;
					end else if (!have) begin
						if (alloc_q) begin
							dir_frame_q[slot_q] <= ntf_q;
							res_created_q       <= 1'b1;
						end else begin
							res_status_q <= ST_NO_TABLE;
						end
					end
				end
				OP_UNMAP: begin
					if (have) begin
						res_frame_q <= e_frame;
					end
				end
				OP_TRANSLATE: begin
					if (have && (!reqp_q || e_present)) begin
						res_frame_q <= e_frame;
					end
				end
				OP_GET_FLAGS: begin
					if (have) begin
						res_flags_q <= e_flags;
					end
				end
				OP_DIRTY: begin
					res_dirty_q <= have && e_present && e_dirty;
				end
				default: begin
					res_dirty_q <= 1'b0;
				end
			endcase
		end
		if (state_q == S_SCAN_END && !(nz_q || rd_nz)) begin
			res_released_q  <= 1'b1;
			res_rel_frame_q <= dir_frame_q[slot_q];
		end
	end

	// output register: the result sits here until its transfer
	logic [FRAME_BITS+FRAME_W-1:0] frame_wide, rel_wide;
	assign frame_wide = {{FRAME_W{1'b0}}, res_frame_q};
	assign rel_wide   = {{FRAME_W{1'b0}}, res_rel_frame_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			m_axis_tdata <= {user_cnt_q, rel_wide[FRAME_W-1:0], res_released_q, res_created_q,
				res_dirty_q, res_flags_q, frame_wide[FRAME_W-1:0], res_status_q};
		end
	end

endmodule
`default_nettype wire

// ===== tb/sv/two_level_page_table_engine_top_test.sv =====
`default_nettype none
module two_level_page_table_engine_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import tlpte_pkg::*;

	// one page table operation as it travels on the input stream
	typedef struct packed {
		logic [2:0]         op;
		logic [VP_W-1:0]    virt_page;
		logic [FRAME_W-1:0] map_frame;
		logic [FRAME_W-1:0] new_table_frame;
		logic               alloc_table;
		logic               kernel_mode;
		logic               not_present;
		logic               require_present;
		logic [FLAG_W-1:0]  flag_bits;
	} pt_op_t;

	// one result, fields from the highest bit down as in m_axis_tdata
	typedef struct packed {
		logic [COUNT_W-1:0] user_pages;
		logic [FRAME_W-1:0] released_table_frame;
		logic               table_released;
		logic               table_created;
		logic               dirty;
		logic [FLAG_W-1:0]  flags_out;
		logic [FRAME_W-1:0] frame_out;
		logic [1:0]         status;
	} pt_result_t;

	// page table shadow and queue of pending results
	class pt_scoreboard;
		logic [31:0]        dir_shadow [16];
		logic [31:0]        entry_shadow [16384];
		logic [COUNT_W-1:0] user_count;
		logic [KTC_W-1:0]   kernel_tables;
		pt_result_t         pending [$];
		int                 errors;

		function new();
			foreach (dir_shadow[i]) dir_shadow[i] = '0;
			foreach (entry_shadow[i]) entry_shadow[i] = '0;
			user_count = '0;
			kernel_tables = KTC_RESET;
			errors = 0;
		endfunction

		function void note_op(pt_op_t t);
			pt_result_t r;
			logic [3:0] slot;
			logic [13:0] idx;
			logic [31:0] e;
			bit have, empty;
			r = '0;
			slot = t.virt_page[13:10];
			idx = t.virt_page;
			have = dir_shadow[slot][BIT_PRESENT];
			e = entry_shadow[idx];
			case (t.op)
				OP_MAP: begin
					if (have && e[BIT_PRESENT] && e[31:12] != 0)
						r.status = ST_MAPPED;
					else if (t.virt_page == 0 || t.map_frame == 0)
						r.status = ST_ZERO;
					else if (!have && !t.alloc_table)
						r.status = ST_NO_TABLE;
					else begin
						if (!have) begin
							dir_shadow[slot] = {t.new_table_frame, 12'h0};
							dir_shadow[slot][BIT_PRESENT] = 1'b1;
							dir_shadow[slot][BIT_WRITABLE] = 1'b1;
							dir_shadow[slot][BIT_USER] = ({1'b0, slot} >= kernel_tables);
							for (int i = 0; i < 1024; i++)
								entry_shadow[{slot, i[9:0]}] = '0;
							r.table_created = 1'b1;
						end
						e = {t.map_frame, 12'h0};
						e[BIT_PRESENT] = !t.not_present;
						e[BIT_WRITABLE] = !t.not_present;
						e[BIT_USER] = !t.kernel_mode;
						entry_shadow[idx] = e;
						if (!t.kernel_mode && !t.not_present && user_count != COUNT_MAX)
							user_count++;
					end
				end
				OP_UNMAP: begin
					if (!have)
						r.status = ST_NO_TABLE;
					else begin
						r.frame_out = e[31:12];
						entry_shadow[idx] = '0;
						empty = 1;
						for (int i = 0; i < 1024; i++)
							if (entry_shadow[{slot, i[9:0]}] != 0) empty = 0;
						if (empty) begin
							r.table_released = 1'b1;
							r.released_table_frame = dir_shadow[slot][31:12];
							dir_shadow[slot] = '0;
						end
						if ({1'b0, slot} >= kernel_tables && e[BIT_PRESENT] && user_count != 0)
							user_count--;
					end
				end
				OP_TRANSLATE: begin
					if (!have) r.status = ST_NO_TABLE;
					else if (!(t.require_present && !e[BIT_PRESENT])) r.frame_out = e[31:12];
				end
				OP_SET_FLAGS: begin
					if (!have) r.status = ST_NO_TABLE;
					else entry_shadow[idx] = e | {20'h0, t.flag_bits};
				end
				OP_GET_FLAGS: begin
					if (!have) r.status = ST_NO_TABLE;
					else r.flags_out = e[11:0];
				end
				OP_DIRTY: begin
					if (!have) r.status = ST_NO_TABLE;
					else r.dirty = e[BIT_PRESENT] & e[BIT_DIRTY];
				end
				default: ;
			endcase
			r.user_pages = user_count;
			pending.push_back(r);
		endfunction

		function void check_result(pt_result_t got);
			pt_result_t exp;
			if (pending.size() == 0) begin
				$display("%t unexpected result %h", $realtime, got);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.status !== exp.status)
				$display("%t status exp %0d got %0d", $realtime, exp.status, got.status);
			if (got.frame_out !== exp.frame_out)
				$display("%t frame_out exp %h got %h", $realtime, exp.frame_out, got.frame_out);
			if (got.flags_out !== exp.flags_out)
				$display("%t flags_out exp %h got %h", $realtime, exp.flags_out, got.flags_out);
			if (got.dirty !== exp.dirty)
				$display("%t dirty exp %b got %b", $realtime, exp.dirty, got.dirty);
			if (got.table_created !== exp.table_created)
				$display("%t table_created exp %b got %b", $realtime, exp.table_created,
					got.table_created);
			if (got.table_released !== exp.table_released)
				$display("%t table_released exp %b got %b", $realtime, exp.table_released,
					got.table_released);
			if (got.released_table_frame !== exp.released_table_frame)
				$display("%t released_table_frame exp %h got %h", $realtime,
					exp.released_table_frame, got.released_table_frame);
			if (got.user_pages !== exp.user_pages)
				$display("%t user_pages exp %0d got %0d", $realtime, exp.user_pages,
					got.user_pages);
			if (got !== exp) errors++;
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [KTC_W-1:0]      cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;  // virt_page, map_frame, new_table_frame, alloc,
	                                      // kernel_mode, not_present, require_present, flags
	logic [2:0]            s_axis_tuser;  // op
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;  // status, frame_out, flags_out, dirty, created,
	                                      // released, released_table_frame, user_pages

	pt_scoreboard tables_sb;
	bit           quiet_phase;   // no idling in the last part
	longint       cycle_count;

	two_level_page_table_engine_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: check each transfer, stall ready in random bursts
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		stall = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				tables_sb.check_result(pt_result_t'(m_axis_tdata));
			if (stall > 0) begin
				stall--;
				m_axis_tready <= 1'b0;
			end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
				stall = $urandom_range(1, 19) - 1;
				m_axis_tready <= 1'b0;
			end else
				m_axis_tready <= 1'b1;
		end
	end

	// watchdog: reports mismatches and stops the run if it does not finish
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 3000000) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// send one operation, with an optional random gap first; valid stays up after the
	// transfer so the next operation can follow directly
	task automatic send_op(pt_op_t t);
		if (!quiet_phase && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= t.op;
		s_axis_tdata <= {2'b0, t.flag_bits, t.require_present, t.not_present, t.kernel_mode,
			t.alloc_table, t.new_table_frame, t.map_frame, t.virt_page};
		do @(posedge clk); while (!s_axis_tready);
		tables_sb.note_op(t);
	endtask

	// write kernel_table_count once the block has drained
	task automatic write_kernel_tables(logic [KTC_W-1:0] value);
		s_axis_tvalid <= 1'b0;
		while (tables_sb.pending.size() != 0) @(posedge clk);
		repeat (1100) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		tables_sb.kernel_tables = value;
		cfg_valid <= 1'b0;
	endtask

	function automatic pt_op_t rand_op(bit well_formed);
		pt_op_t t;
		t = '0;
		t.op = well_formed ? 3'($urandom_range(0, 5)) : 3'($urandom_range(0, 7));
		// few slots and few entries so pages get reused and tables empty out
		t.virt_page = well_formed ? {$urandom_range(0, 15) == 0 ? 4'($urandom) :
			4'($urandom_range(0, 3)), 10'($urandom_range(0, 7))} : 14'($urandom);
		t.map_frame = $urandom_range(0, 15) == 0 ? 20'h0 : 20'($urandom);
		t.new_table_frame = 20'($urandom);
		t.alloc_table = $urandom_range(0, 4) != 0;
		t.kernel_mode = $urandom_range(0, 3) == 0;
		t.not_present = $urandom_range(0, 4) == 0;
		t.require_present = 1'($urandom);
		t.flag_bits = $urandom_range(0, 1) ? 12'($urandom) : 12'h040;
		return t;
	endfunction

	initial begin
		pt_op_t t;
		int wait_cycles;
		tables_sb = new();
		quiet_phase = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: no table, zero page/frame, create, remap, flags, dirty, unmap release
		t = '0; t.op = OP_TRANSLATE; t.virt_page = 14'h0405; send_op(t);
		t = '0; t.op = OP_MAP; t.virt_page = 14'h0405; t.map_frame = 20'h12345; send_op(t);
		t.alloc_table = 1; t.map_frame = 0; send_op(t);
		t.virt_page = 0; t.map_frame = 20'h1; send_op(t);
		t.virt_page = 14'h0405; t.map_frame = 20'hFFFFF; t.new_table_frame = 20'h0;
		send_op(t);
		send_op(t);
		t = '0; t.op = OP_MAP; t.virt_page = 14'h3FFF; t.map_frame = 20'h1;
		t.new_table_frame = 20'hFFFFF; t.alloc_table = 1; t.kernel_mode = 1; send_op(t);
		t.virt_page = 14'h3C00; t.kernel_mode = 0; t.not_present = 1; send_op(t);
		t = '0; t.op = OP_SET_FLAGS; t.virt_page = 14'h3FFF; t.flag_bits = 12'hFFF; send_op(t);
		t.op = OP_GET_FLAGS; send_op(t);
		t.op = OP_DIRTY; send_op(t);
		t.virt_page = 14'h3C00; send_op(t);
		t.op = OP_TRANSLATE; t.require_present = 1; send_op(t);
		t.require_present = 0; send_op(t);
		t.op = 3'd6; send_op(t);
		t.op = 3'd7; send_op(t);
		t.op = OP_UNMAP; t.virt_page = 14'h3FFF; send_op(t);
		t.virt_page = 14'h3C00; send_op(t);
		t.virt_page = 14'h0405; send_op(t);
		t.op = OP_GET_FLAGS; send_op(t);

		// random phases under several kernel_table_count settings
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: write_kernel_tables(5'd0);
				1: write_kernel_tables(5'd16);
				2: write_kernel_tables(5'd31);
				3: write_kernel_tables(5'd2);
				4: write_kernel_tables(5'd8);
				default: write_kernel_tables(5'($urandom_range(0, 16)));
			endcase
			if (phase == 5) quiet_phase = 1;
			for (int n = 0; n < 93; n++)
				send_op(rand_op($urandom_range(0, 9) != 0));
		end

		s_axis_tvalid <= 1'b0;
		wait_cycles = 0;
		while (tables_sb.pending.size() != 0 && wait_cycles < 200000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (1100) @(posedge clk);
		if (tables_sb.errors == 0 && tables_sb.pending.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
`default_nettype wire
